// File: src/trilinear_corner_interpolation_unit_macros.svh
// Assertion macros used by the RTL divider (tciu_div).
`ifndef TRILINEAR_CORNER_INTERPOLATION_UNIT_MACROS_SVH
`define TRILINEAR_CORNER_INTERPOLATION_UNIT_MACROS_SVH

// Condition must never be true out of reset.
`define TCIU_ASSERT_NEVER(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("assertion failed: condition must never hold");

// Antecedent implies consequent in the same cycle.
`define TCIU_ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication violated");

`endif

// File: src/tciu_pkg.sv
package tciu_pkg;

    localparam int COORD_BITS = 16;
    localparam int POWER_BITS = 32;
    localparam int WFRAC      = 30;
    localparam int W_BITS     = 32;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int FDIV_NW    = DIFF_BITS + WFRAC;
    localparam int PROD_BITS  = W_BITS + POWER_BITS;
    localparam int ACC_BITS   = PROD_BITS + 3;
    localparam int SUM_BITS   = W_BITS + 3;
    localparam int DIV_NW     = (FDIV_NW > ACC_BITS) ? FDIV_NW : ACC_BITS;
    localparam int DIV_DW     = (DIFF_BITS > SUM_BITS) ? DIFF_BITS : SUM_BITS;

    typedef logic [1:0] t_axis;
    localparam t_axis AX_Z = 2'd0;
    localparam t_axis AX_Y = 2'd1;
    localparam t_axis AX_X = 2'd2;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic                          func;
        logic [2:0]                    corner_index;
        logic signed [COORD_BITS-1:0]  coord_x;
        logic signed [COORD_BITS-1:0]  coord_y;
        logic signed [COORD_BITS-1:0]  coord_z;
        logic signed [POWER_BITS-1:0]  power_in;
    } t_in_item;

    typedef struct packed {
        logic signed [POWER_BITS-1:0]  power_out;
        logic                          divide_error;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_FACT,
        ST_FWAIT,
        ST_WMUL_A,
        ST_WMUL_B,
        ST_PMUL,
        ST_PWAIT,
        ST_ACC,
        ST_CHECK,
        ST_QWAIT,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic       take;
        logic       rd;
        logic       fact_start;
        logic       fact_cap;
        logic       wmul_a;
        logic       wmul_b;
        logic       pmul_start;
        logic       acc_add;
        logic       res_err;
        logic       final_start;
        logic       final_cap;
        logic       out_load;
        logic [2:0] corner;
        t_axis      axis;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic mul_done;
        logic fail;
        logic slot_free;
    } t_status;

    function automatic logic [2:0] corner_nbr(input logic [2:0] k, input t_axis axis);
        logic [2:0] r;
        unique case (axis)
            AX_Z:    r = k ^ 3'd1;
            AX_Y:    r = k ^ 3'd3;
            default: r = k ^ 3'd7;
        endcase
        return r;
    endfunction

    function automatic logic [W_BITS-1:0] mag_w(input logic signed [W_BITS-1:0] a);
        return a[W_BITS-1] ? (W_BITS'(0) - $unsigned(a)) : $unsigned(a);
    endfunction

    function automatic logic signed [W_BITS-1:0] sat_w(
        input logic              big,
        input logic [W_BITS-1:0] m,
        input logic              neg
    );
        logic signed [W_BITS-1:0] r;
        logic [W_BITS-1:0]        lim_n;
        lim_n = {1'b1, {(W_BITS-1){1'b0}}};
        if (neg) begin
            r = (big || (m > lim_n)) ? $signed(lim_n) : $signed(W_BITS'(0) - m);
        end else begin
            r = (big || m[W_BITS-1]) ? $signed(lim_n - W_BITS'(1)) : $signed(m);
        end
        return r;
    endfunction

endpackage

// File: src/tciu_div.sv
`include "trilinear_corner_interpolation_unit_macros.svh"

module tciu_div
    import tciu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_NW-1:0] i_dividend,
    input  logic [DIV_DW-1:0] i_divisor,
    output logic              o_done,
    output logic [DIV_NW-1:0] o_quot
);

    localparam int CNT_W = $clog2(DIV_NW + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIV_NW-1:0] r_n;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_d;
    logic [DIV_DW:0]   rem_sh;
    logic              ge;

    assign rem_sh = {r_rem, r_n[DIV_NW-1]};
    assign ge     = rem_sh >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= i_dividend;
            r_d   <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_n   <= {r_n[DIV_NW-2:0], ge};
            r_rem <= ge ? DIV_DW'(rem_sh - {1'b0, r_d}) : DIV_DW'(rem_sh);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_n;

    `TCIU_ASSERT_NEVER(a_start_busy, i_clk, i_rst_n, i_start && r_busy)
    `TCIU_ASSERT_IMPLIES(a_done_idle, i_clk, i_rst_n, r_done, !r_busy)
    `TCIU_ASSERT_IMPLIES(a_busy_cnt, i_clk, i_rst_n, r_busy, r_cnt != '0)

endmodule

// File: src/tciu_datapath.sv
module tciu_datapath
    import tciu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  t_in_item  i_in_item,
    input  logic      i_out_stall,
    output t_status   o_status,
    output logic      o_out_valid,
    output t_out_item o_out_item
);

    localparam int MCNT_W = $clog2(POWER_BITS + 1);

    logic signed [COORD_BITS-1:0] mem_x [8];
    logic signed [COORD_BITS-1:0] mem_y [8];
    logic signed [COORD_BITS-1:0] mem_z [8];
    logic signed [POWER_BITS-1:0] mem_p [8];

    t_in_item                     r_item;
    logic signed [COORD_BITS-1:0] r_own_c;
    logic signed [COORD_BITS-1:0] r_nbr_c;
    logic signed [POWER_BITS-1:0] r_own_p;
    logic                         r_err;
    logic                         r_fneg;
    logic signed [W_BITS-1:0]     r_fz;
    logic signed [W_BITS-1:0]     r_fy;
    logic signed [W_BITS-1:0]     r_fx;
    logic signed [W_BITS-1:0]     r_w;
    logic [PROD_BITS-1:0]         r_mcand;
    logic [POWER_BITS-1:0]        r_mplier;
    logic [PROD_BITS-1:0]         r_prod;
    logic [MCNT_W-1:0]            r_mcnt;
    logic                         r_mbusy;
    logic                         r_mdone;
    logic                         r_pneg;
    logic signed [ACC_BITS-1:0]   r_acc;
    logic signed [SUM_BITS-1:0]   r_sum;
    logic                         r_rneg;
    t_out_item                    r_res;
    t_out_item                    r_out;
    logic                         r_out_valid;

    logic [2:0]                   nb;
    logic signed [COORD_BITS-1:0] q_sel;
    logic signed [DIFF_BITS-1:0]  d_den;
    logic signed [DIFF_BITS-1:0]  d_num;
    logic [DIFF_BITS-1:0]         m_den;
    logic [DIFF_BITS-1:0]         m_num;
    logic [ACC_BITS-1:0]          m_acc;
    logic [SUM_BITS-1:0]          m_sum;
    logic                         div_start;
    logic [DIV_NW-1:0]            div_dividend;
    logic [DIV_DW-1:0]            div_divisor;
    logic                         div_done;
    logic [DIV_NW-1:0]            div_quot;
    logic signed [W_BITS-1:0]     fact_val;
    logic signed [W_BITS-1:0]     mul_a;
    logic signed [W_BITS-1:0]     mul_b;
    logic [2*W_BITS-1:0]          mul_p;
    logic [POWER_BITS-1:0]        res_m;
    logic                         res_over;
    logic [POWER_BITS-1:0]        res_lim;
    logic [ACC_BITS-1:0]          prod_ext;

    assign nb = corner_nbr(i_cmd.corner, i_cmd.axis);

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && (i_in_item.func == FUNC_LOAD)) begin
            mem_x[i_in_item.corner_index] <= i_in_item.coord_x;
            mem_y[i_in_item.corner_index] <= i_in_item.coord_y;
            mem_z[i_in_item.corner_index] <= i_in_item.coord_z;
            mem_p[i_in_item.corner_index] <= i_in_item.power_in;
        end
        if (i_cmd.rd) begin
            r_own_p <= mem_p[i_cmd.corner];
            unique case (i_cmd.axis)
                AX_Z: begin
                    r_own_c <= mem_z[i_cmd.corner];
                    r_nbr_c <= mem_z[nb];
                end
                AX_Y: begin
                    r_own_c <= mem_y[i_cmd.corner];
                    r_nbr_c <= mem_y[nb];
                end
                default: begin
                    r_own_c <= mem_x[i_cmd.corner];
                    r_nbr_c <= mem_x[nb];
                end
            endcase
        end
    end

    always_comb begin
        unique case (i_cmd.axis)
            AX_Z:    q_sel = r_item.coord_z;
            AX_Y:    q_sel = r_item.coord_y;
            default: q_sel = r_item.coord_x;
        endcase
    end

    assign d_den = DIFF_BITS'(r_nbr_c) - DIFF_BITS'(r_own_c);
    assign d_num = DIFF_BITS'(r_nbr_c) - DIFF_BITS'(q_sel);
    assign m_den = d_den[DIFF_BITS-1] ? (DIFF_BITS'(0) - $unsigned(d_den)) : $unsigned(d_den);
    assign m_num = d_num[DIFF_BITS-1] ? (DIFF_BITS'(0) - $unsigned(d_num)) : $unsigned(d_num);
    assign m_acc = r_acc[ACC_BITS-1] ? (ACC_BITS'(0) - $unsigned(r_acc)) : $unsigned(r_acc);
    assign m_sum = r_sum[SUM_BITS-1] ? (SUM_BITS'(0) - $unsigned(r_sum)) : $unsigned(r_sum);

    assign div_start    = i_cmd.fact_start | i_cmd.final_start;
    assign div_dividend = i_cmd.final_start ? DIV_NW'(m_acc)
                                            : DIV_NW'({m_num, {WFRAC{1'b0}}});
    assign div_divisor  = i_cmd.final_start ? DIV_DW'(m_sum) : DIV_DW'(m_den);

    tciu_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    assign fact_val = sat_w(|div_quot[DIV_NW-1:W_BITS], div_quot[W_BITS-1:0], r_fneg);

    assign mul_a = i_cmd.wmul_b ? r_w  : r_fz;
    assign mul_b = i_cmd.wmul_b ? r_fx : r_fy;
    assign mul_p = mag_w(mul_a) * mag_w(mul_b);

    assign res_lim  = r_rneg ? {1'b1, {(POWER_BITS-1){1'b0}}}
                             : {1'b0, {(POWER_BITS-1){1'b1}}};
    assign res_over = r_rneg ? ((|div_quot[DIV_NW-1:POWER_BITS])
                                || (div_quot[POWER_BITS-1:0] > res_lim))
                             : (|div_quot[DIV_NW-1:POWER_BITS-1]);
    assign res_m    = res_over ? res_lim : div_quot[POWER_BITS-1:0];

    assign prod_ext = ACC_BITS'(r_prod);

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && (i_in_item.func == FUNC_QUERY)) begin
            r_item <= i_in_item;
            r_acc  <= '0;
            r_sum  <= '0;
        end
        if (i_cmd.fact_start) begin
            r_fneg <= d_num[DIFF_BITS-1] ^ d_den[DIFF_BITS-1];
        end
        if (i_cmd.fact_cap) begin
            unique case (i_cmd.axis)
                AX_Z:    r_fz <= fact_val;
                AX_Y:    r_fy <= fact_val;
                default: r_fx <= fact_val;
            endcase
        end
        if (i_cmd.wmul_a || i_cmd.wmul_b) begin
            r_w <= sat_w(|mul_p[2*W_BITS-1:W_BITS+WFRAC], mul_p[W_BITS+WFRAC-1:WFRAC],
                         mul_a[W_BITS-1] ^ mul_b[W_BITS-1]);
        end
        if (i_cmd.pmul_start) begin
            r_mcand  <= PROD_BITS'(mag_w(r_w));
            r_mplier <= r_own_p[POWER_BITS-1] ? (POWER_BITS'(0) - $unsigned(r_own_p))
                                              : $unsigned(r_own_p);
            r_prod   <= '0;
            r_pneg   <= r_w[W_BITS-1] ^ r_own_p[POWER_BITS-1];
        end else if (r_mbusy) begin
            if (r_mplier[0]) begin
                r_prod <= r_prod + r_mcand;
            end
            r_mcand  <= {r_mcand[PROD_BITS-2:0], 1'b0};
            r_mplier <= {1'b0, r_mplier[POWER_BITS-1:1]};
        end
        if (i_cmd.acc_add) begin
            r_acc <= r_acc + $signed(r_pneg ? (ACC_BITS'(0) - prod_ext) : prod_ext);
            r_sum <= r_sum + SUM_BITS'(r_w);
        end
        if (i_cmd.final_start) begin
            r_rneg <= r_acc[ACC_BITS-1] ^ r_sum[SUM_BITS-1];
        end
        if (i_cmd.res_err) begin
            r_res.power_out    <= '0;
            r_res.divide_error <= 1'b1;
        end else if (i_cmd.final_cap) begin
            r_res.power_out    <= $signed(r_rneg ? (POWER_BITS'(0) - res_m) : res_m);
            r_res.divide_error <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err       <= 1'b0;
            r_mbusy     <= 1'b0;
            r_mdone     <= 1'b0;
            r_mcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.take) begin
                r_err <= 1'b0;
            end else if (i_cmd.fact_start && (d_den == '0)) begin
                r_err <= 1'b1;
            end
            r_mdone <= 1'b0;
            if (i_cmd.pmul_start) begin
                r_mbusy <= 1'b1;
                r_mcnt  <= MCNT_W'(POWER_BITS);
            end else if (r_mbusy) begin
                r_mcnt <= r_mcnt - MCNT_W'(1);
                if (r_mcnt == MCNT_W'(1)) begin
                    r_mbusy <= 1'b0;
                    r_mdone <= 1'b1;
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.div_done  = div_done;
    assign o_status.mul_done  = r_mdone;
    assign o_status.fail      = r_err | (r_sum == '0);
    assign o_status.slot_free = !r_out_valid | !i_out_stall;
    assign o_out_valid        = r_out_valid;
    assign o_out_item         = r_out;

endmodule

// File: src/tciu_ctrl.sv
module tciu_ctrl
    import tciu_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_func,
    input  t_status i_status,
    output logic    o_in_stall,
    output t_cmd    o_cmd
);

    t_state     r_state;
    t_state     n_state;
    logic [2:0] r_k;
    logic [2:0] n_k;
    t_axis      r_axis;
    t_axis      n_axis;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k     <= '0;
            r_axis  <= AX_Z;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_axis  <= n_axis;
        end
    end

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_axis  = r_axis;
        unique case (r_state)
            ST_IDLE: begin
                n_k    = '0;
                n_axis = AX_Z;
                if (i_in_valid && (i_in_func == FUNC_QUERY)) begin
                    n_state = ST_READ;
                end
            end
            ST_READ:  n_state = ST_FACT;
            ST_FACT:  n_state = ST_FWAIT;
            ST_FWAIT: begin
                if (i_status.div_done) begin
                    if (r_axis == AX_X) begin
                        n_state = ST_WMUL_A;
                    end else begin
                        n_axis  = r_axis + t_axis'(1);
                        n_state = ST_READ;
                    end
                end
            end
            ST_WMUL_A: n_state = ST_WMUL_B;
            ST_WMUL_B: n_state = ST_PMUL;
            ST_PMUL:   n_state = ST_PWAIT;
            ST_PWAIT: begin
                if (i_status.mul_done) begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC: begin
                n_axis = AX_Z;
                n_k    = r_k + 3'd1;
                n_state = (r_k == 3'd7) ? ST_CHECK : ST_READ;
            end
            ST_CHECK: n_state = i_status.fail ? ST_EMIT : ST_QWAIT;
            ST_QWAIT: begin
                if (i_status.div_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_status.slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.corner = r_k;
        o_cmd.axis   = r_axis;
        unique case (r_state)
            ST_IDLE:   o_cmd.take        = i_in_valid;
            ST_READ:   o_cmd.rd          = 1'b1;
            ST_FACT:   o_cmd.fact_start  = 1'b1;
            ST_FWAIT:  o_cmd.fact_cap    = i_status.div_done;
            ST_WMUL_A: o_cmd.wmul_a      = 1'b1;
            ST_WMUL_B: o_cmd.wmul_b      = 1'b1;
            ST_PMUL:   o_cmd.pmul_start  = 1'b1;
            ST_ACC:    o_cmd.acc_add     = 1'b1;
            ST_CHECK: begin
                o_cmd.res_err     = i_status.fail;
                o_cmd.final_start = !i_status.fail;
            end
            ST_QWAIT:  o_cmd.final_cap   = i_status.div_done;
            ST_EMIT:   o_cmd.out_load    = i_status.slot_free;
            default:   o_cmd.take        = 1'b0;
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

// File: src/trilinear_corner_interpolation_unit.sv
// Trilinear interpolation over eight stored box corners. A load item writes one
// corner and gives no result. A query item gives exactly one result: the 24
// axis factors and the final quotient all run through one shared divider that
// retires one quotient bit per cycle, and each weight-times-power product uses
// a shift-add multiplier, one bit per cycle. One query is in work at a time; a
// finished result waits in the output register while the next item is taken.
module trilinear_corner_interpolation_unit
    import tciu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_cmd    cmd;
    t_status status;

    tciu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_func  (i_in_item.func),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    tciu_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_item   (i_in_item),
        .i_out_stall (i_out_stall),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

// File: dv/testbench.sv
module testbench;
    import tciu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CYCLE_LIMIT  = 8000000;
    localparam int  RANDOM_ITEMS = 560;
    localparam int  QUIET_ITEMS  = 60;
    localparam int  DRAIN_CYCLES = 64;
    localparam logic [63:0] Q30_POS_MAX = 64'h7FFF_FFFF;
    localparam logic [63:0] Q30_NEG_MAX = 64'h8000_0000;

    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item result;
    } t_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_item;

    longint    box_x[8];
    longint    box_y[8];
    longint    box_z[8];
    longint    box_power[8];
    t_out_item pending_results[$];
    t_row      directed_rows[$];
    int        error_count = 0;
    int        cycle_count = 0;
    int        stall_burst = 0;
    bit        quiet = 1'b0;

    trilinear_corner_interpolation_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always #2 i_clk = ~i_clk;

    function automatic longint sat_q30(input logic [63:0] m, input bit neg);
        if (neg) begin
            return (m > Q30_NEG_MAX) ? -longint'(Q30_NEG_MAX) : -longint'(m);
        end
        return (m > Q30_POS_MAX) ? longint'(Q30_POS_MAX) : longint'(m);
    endfunction

    function automatic logic [63:0] abs64(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint edge_factor(input longint nbr, input longint q,
                                           input longint own, inout bit err);
        longint den;
        longint num;
        den = nbr - own;
        num = nbr - q;
        if (den == 0) begin
            err = 1'b1;
            return 0;
        end
        return sat_q30((abs64(num) << WFRAC) / abs64(den), (num < 0) != (den < 0));
    endfunction

    function automatic longint weight_mul(input longint a, input longint b);
        return sat_q30((abs64(a) * abs64(b)) >> WFRAC, (a < 0) != (b < 0));
    endfunction

    function automatic t_out_item interpolate(input t_in_item it);
        t_out_item           r;
        bit                  err;
        longint              fz, fy, fx, w, wsum;
        logic signed [127:0] acc, prod, quo;
        err  = 1'b0;
        wsum = 0;
        acc  = '0;
        for (int k = 0; k < 8; k++) begin
            fz = edge_factor(box_z[k ^ 1], longint'(it.coord_z), box_z[k], err);
            fy = edge_factor(box_y[k ^ 3], longint'(it.coord_y), box_y[k], err);
            fx = edge_factor(box_x[k ^ 7], longint'(it.coord_x), box_x[k], err);
            w = weight_mul(weight_mul(fz, fy), fx);
            prod = 128'(w);
            prod = prod * 128'(box_power[k]);
            acc = acc + prod;
            wsum += w;
        end
        r = '0;
        if (err || wsum == 0) begin
            r.divide_error = 1'b1;
            return r;
        end
        quo = acc / 128'(wsum);
        if (quo > 128'sh7FFF_FFFF) begin
            quo = 128'sh7FFF_FFFF;
        end else if (quo < -128'sh8000_0000) begin
            quo = -128'sh8000_0000;
        end
        r.power_out = quo[31:0];
        return r;
    endfunction

    function automatic t_in_item box_corner(input int k, input int x0, input int x1,
                                            input int y0, input int y1, input int z0,
                                            input int z1, input logic [31:0] p);
        t_in_item it;
        it.func         = FUNC_LOAD;
        it.corner_index = 3'(k);
        it.coord_x      = 16'(k[2] ? x1 : x0);
        it.coord_y      = 16'(k[1] ? y1 : y0);
        it.coord_z      = 16'(k[0] ? z1 : z0);
        it.power_in     = p;
        return it;
    endfunction

    function automatic t_in_item query_at(input int x, input int y, input int z,
                                          input logic [2:0] idx, input logic [31:0] p);
        t_in_item it;
        it.func         = FUNC_QUERY;
        it.corner_index = idx;
        it.coord_x      = 16'(x);
        it.coord_y      = 16'(y);
        it.coord_z      = 16'(z);
        it.power_in     = p;
        return it;
    endfunction

    task automatic send_item(input t_in_item it, input bit typed, input t_out_item res);
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (it.func == FUNC_LOAD) begin
            box_x[it.corner_index]     = longint'(it.coord_x);
            box_y[it.corner_index]     = longint'(it.coord_y);
            box_z[it.corner_index]     = longint'(it.coord_z);
            box_power[it.corner_index] = longint'(it.power_in);
        end else begin
            pending_results.push_back(typed ? res : interpolate(it));
        end
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    task automatic send_plain(input t_in_item it);
        send_item(it, 1'b0, '0);
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (stall_burst > 0) begin
            stall_burst <= stall_burst - 1;
            i_out_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_burst <= $urandom_range(0, 17);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected item, actual %h", $time, o_out_item);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_out_item.power_out !== want.power_out) begin
                    $display("%0t: power_out expected %h actual %h", $time,
                             want.power_out, o_out_item.power_out);
                    error_count++;
                end
                if (o_out_item.divide_error !== want.divide_error) begin
                    $display("%0t: divide_error expected %b actual %b", $time,
                             want.divide_error, o_out_item.divide_error);
                    error_count++;
                end
            end
        end
    end

    initial begin
        t_row      row;
        t_out_item err_res;
        int        x0, x1, y0, y1, z0, z1, sel, sent;
        bit        drained;
        err_res = '0;
        err_res.divide_error = 1'b1;
        drained = 1'b0;

        for (int k = 0; k < 8; k++) begin
            row.item = box_corner(k, -32768, 32767, -32768, 32767, -32768, 32767,
                                  (k == 0) ? 32'h7FFF_FFFF : (k == 1) ? 32'h8000_0000 :
                                  (k == 2) ? 32'h0 : (k == 3) ? 32'hFFFF_FFFF :
                                  32'($urandom));
            row.typed = 1'b0;
            directed_rows.push_back(row);
        end
        row.typed = 1'b0;
        row.item = query_at(0, 0, 0, 3'd0, 32'h0);
        directed_rows.push_back(row);
        row.item = query_at(-32768, -32768, -32768, 3'd7, 32'hFFFF_FFFF);
        directed_rows.push_back(row);
        row.item = query_at(32767, 32767, 32767, 3'd5, 32'($urandom));
        directed_rows.push_back(row);
        row.item = box_corner(1, -32768, 32767, -32768, 32767, -32768, -32768, 32'h1);
        directed_rows.push_back(row);
        row.item = query_at(100, -100, 5, 3'd2, 32'h0);
        row.typed = 1'b1;
        row.result = err_res;
        directed_rows.push_back(row);
        row.typed = 1'b0;
        for (int k = 0; k < 8; k++) begin
            row.item = box_corner(k, 0, 1, 0, 1, 0, 1, 32'h7FFF_FFFF);
            directed_rows.push_back(row);
        end
        row.item = query_at(1000, 700, 32767, 3'd1, 32'h0);
        directed_rows.push_back(row);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].item, directed_rows[i].typed,
                      directed_rows[i].result);
        end

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            quiet = (RANDOM_ITEMS - sent) < QUIET_ITEMS;
            if (sent >= 280 && !drained) begin
                drained = 1'b1;
                i_in_valid <= 1'b0;
                wait (pending_results.size() == 0);
                @(posedge i_clk);
            end
            sel = $urandom_range(0, 9);
            if (sel <= 5) begin
                if ($urandom_range(0, 2) == 0) begin
                    send_plain(query_at($urandom, $urandom, $urandom, 3'($urandom),
                                        $urandom));
                end else begin
                    send_plain(query_at(box_x[0] + $urandom_range(0, 64) - 8,
                                        box_y[0] + $urandom_range(0, 64) - 8,
                                        box_z[0] + $urandom_range(0, 64) - 8,
                                        3'($urandom), $urandom));
                end
                sent++;
            end else if (sel <= 7) begin
                if ($urandom_range(0, 1) == 0) begin
                    x0 = $signed(16'($urandom));
                    y0 = $signed(16'($urandom));
                    z0 = $signed(16'($urandom));
                    x1 = $signed(16'($urandom));
                    y1 = $signed(16'($urandom));
                    z1 = $signed(16'($urandom));
                end else begin
                    x0 = $urandom_range(0, 2000) - 1000;
                    y0 = $urandom_range(0, 2000) - 1000;
                    z0 = $urandom_range(0, 2000) - 1000;
                    x1 = x0 + $urandom_range(1, 40);
                    y1 = y0 + $urandom_range(1, 40);
                    z1 = z0 + $urandom_range(1, 40);
                end
                for (int k = 0; k < 8; k++) begin
                    send_plain(box_corner(k, x0, x1, y0, y1, z0, z1,
                                          ($urandom_range(0, 1) == 0) ? $urandom :
                                          $urandom_range(0, 32'h000F_FFFF)));
                end
                sent += 8;
            end else begin
                t_in_item it;
                it = t_in_item'(84'({$urandom, $urandom, $urandom}));
                it.func = FUNC_LOAD;
                send_plain(it);
                sent++;
            end
        end
        i_in_valid <= 1'b0;

        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end
endmodule

// File: sim.f
+incdir+src
src/tciu_pkg.sv
src/tciu_div.sv
src/tciu_datapath.sv
src/tciu_ctrl.sv
src/trilinear_corner_interpolation_unit.sv
dv/testbench.sv
